// ----- src/sfg_pkg.sv -----
// shared types, constants and frame layout for the scoreboard frame generator
`default_nettype none
package sfg_pkg;

    localparam int BYTES_PER_FRAME = 17;
    localparam int POS_W       = $clog2(BYTES_PER_FRAME);
    localparam int LAST_POS    = BYTES_PER_FRAME - 1;
    localparam int NUM_SLOTS   = 6;
    localparam int QUEUE_DEPTH = 2;

    // request kinds
    localparam logic [1:0] REQ_MATCH    = 2'd0;
    localparam logic [1:0] REQ_BLANK    = 2'd1;
    localparam logic [1:0] REQ_EXERCISE = 2'd2;
    localparam logic [1:0] REQ_TEST     = 2'd3;

    // clock arithmetic
    localparam int CLOCK_LIMIT  = 5999;
    localparam int CLOCK_W      = 13;
    localparam int SECS_PER_MIN = 60;
    // floor(s / 60) == (s * MIN_RECIP) >> MIN_SHIFT for s up to the clock limit
    localparam int MIN_RECIP    = 8739;
    localparam int MIN_SHIFT    = 19;
    // floor(v / 10) == (v * DIV10_RECIP) >> DIV10_SHIFT for v up to 255
    localparam int DIV10_RECIP  = 205;
    localparam int DIV10_SHIFT  = 11;

    // ascii
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_EIGHT = 8'h38;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_CR    = 8'h0D;

    // frame positions of the digit slots
    localparam logic [POS_W-1:0] POS_HOME     = POS_W'(4);
    localparam logic [POS_W-1:0] POS_AWAY     = POS_W'(6);
    localparam logic [POS_W-1:0] POS_MIN_TENS = POS_W'(11);
    localparam logic [POS_W-1:0] POS_MIN_UNIT = POS_W'(12);
    localparam logic [POS_W-1:0] POS_SEC_TENS = POS_W'(14);
    localparam logic [POS_W-1:0] POS_SEC_UNIT = POS_W'(15);
    localparam logic [POS_W-1:0] POS_END      = POS_W'(LAST_POS);

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  home_score;
        logic [7:0]  away_score;
        logic [15:0] game_secs;
        logic [5:0]  digit_mask;
        logic [7:0]  exercise_value;
    } t_req;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
    } t_res;

    // one character per digit slot, slot 0 is the home score
    typedef logic [NUM_SLOTS-1:0][7:0] t_slots;

    function automatic logic [7:0] frame_char(input logic [POS_W-1:0] pos, input t_slots s);
        logic [7:0] c;
        case (pos) inside
            POS_W'(0), POS_W'(1), POS_W'(2): c = CHAR_ZERO;
            POS_HOME:                        c = s[0];
            POS_AWAY:                        c = s[1];
            POS_MIN_TENS:                    c = s[2];
            POS_MIN_UNIT:                    c = s[3];
            POS_SEC_TENS:                    c = s[4];
            POS_SEC_UNIT:                    c = s[5];
            POS_END:                         c = CHAR_CR;
            default:                         c = CHAR_SPACE;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

// ----- src/sfg_front.sv -----
// front end: accepts requests and works out the six slot characters in two stages
`default_nettype none
module sfg_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_req_valid,
    output logic                 o_req_ready,
    input  wire sfg_pkg::t_req   i_req,
    output logic                 o_slots_valid,
    input  wire logic            i_slots_ready,
    output sfg_pkg::t_slots      o_slots
);

    localparam int CW = sfg_pkg::CLOCK_W;

    // remainder by ten from the value and its reciprocal product
    function automatic logic [3:0] rem10(input logic [7:0] v, input logic [15:0] p);
        logic [7:0] q;
        logic [7:0] r;
        q = 8'(p >> sfg_pkg::DIV10_SHIFT);
        r = v - q * 8'd10;
        return r[3:0];
    endfunction

    // stage a
    logic            r_a_valid;
    logic [1:0]      r_a_kind;
    logic [5:0]      r_a_mask;
    logic [7:0]      r_a_home;
    logic [7:0]      r_a_away;
    logic [7:0]      r_a_val;
    logic [15:0]     r_a_p_home;
    logic [15:0]     r_a_p_away;
    logic [15:0]     r_a_p_val;
    logic [CW-1:0]   r_a_clamped;
    logic [25:0]     r_a_p_sec;

    // stage b
    logic            r_b_valid;
    logic [1:0]      r_b_kind;
    logic [5:0]      r_b_mask;
    logic [3:0]      r_b_home;
    logic [3:0]      r_b_away;
    logic [3:0]      r_b_val;
    logic [6:0]      r_b_min;
    logic [5:0]      r_b_sec;

    logic            w_a_ready;
    logic            w_b_ready;
    logic [CW-1:0]   w_clamped;
    logic [6:0]      w_min;
    logic [CW-1:0]   w_sec_rem;
    logic [14:0]     w_p_min;
    logic [14:0]     w_p_sec10;
    logic [3:0]      w_min_tens;
    logic [3:0]      w_sec_tens;
    logic [6:0]      w_min_unit;
    logic [5:0]      w_sec_unit;

    assign w_b_ready   = !r_b_valid || i_slots_ready;
    assign w_a_ready   = !r_a_valid || w_b_ready;
    assign o_req_ready = w_a_ready;

    assign w_clamped = (i_req.game_secs > 16'(sfg_pkg::CLOCK_LIMIT))
                       ? CW'(sfg_pkg::CLOCK_LIMIT) : i_req.game_secs[CW-1:0];

    assign w_min     = 7'(r_a_p_sec >> sfg_pkg::MIN_SHIFT);
    assign w_sec_rem = r_a_clamped - CW'(w_min) * CW'(sfg_pkg::SECS_PER_MIN);

    assign w_p_min    = 15'(r_b_min) * 15'(sfg_pkg::DIV10_RECIP);
    assign w_p_sec10  = 15'(r_b_sec) * 15'(sfg_pkg::DIV10_RECIP);
    assign w_min_tens = 4'(w_p_min >> sfg_pkg::DIV10_SHIFT);
    assign w_sec_tens = 4'(w_p_sec10 >> sfg_pkg::DIV10_SHIFT);
    assign w_min_unit = r_b_min - 7'(w_min_tens) * 7'd10;
    assign w_sec_unit = r_b_sec - 6'(w_sec_tens) * 6'd10;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (w_a_ready) begin
                r_a_valid <= i_req_valid;
            end
            if (w_b_ready) begin
                r_b_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_a_ready && i_req_valid) begin
            r_a_kind    <= i_req.req_type;
            r_a_mask    <= i_req.digit_mask;
            r_a_home    <= i_req.home_score;
            r_a_away    <= i_req.away_score;
            r_a_val     <= i_req.exercise_value;
            r_a_p_home  <= 16'(i_req.home_score) * 16'(sfg_pkg::DIV10_RECIP);
            r_a_p_away  <= 16'(i_req.away_score) * 16'(sfg_pkg::DIV10_RECIP);
            r_a_p_val   <= 16'(i_req.exercise_value) * 16'(sfg_pkg::DIV10_RECIP);
            r_a_clamped <= w_clamped;
            r_a_p_sec   <= 26'(w_clamped) * 26'(sfg_pkg::MIN_RECIP);
        end
        if (w_b_ready && r_a_valid) begin
            r_b_kind <= r_a_kind;
            r_b_mask <= r_a_mask;
            r_b_home <= rem10(r_a_home, r_a_p_home);
            r_b_away <= rem10(r_a_away, r_a_p_away);
            r_b_val  <= rem10(r_a_val, r_a_p_val);
            r_b_min  <= w_min;
            r_b_sec  <= w_sec_rem[5:0];
        end
    end

    always_comb begin
        o_slots = '{default: sfg_pkg::CHAR_SPACE};
        unique case (r_b_kind)
            sfg_pkg::REQ_MATCH: begin
                o_slots[0] = sfg_pkg::CHAR_ZERO + 8'(r_b_home);
                o_slots[1] = sfg_pkg::CHAR_ZERO + 8'(r_b_away);
                o_slots[2] = sfg_pkg::CHAR_ZERO + 8'(w_min_tens);
                o_slots[3] = sfg_pkg::CHAR_ZERO + 8'(w_min_unit[3:0]);
                o_slots[4] = sfg_pkg::CHAR_ZERO + 8'(w_sec_tens);
                o_slots[5] = sfg_pkg::CHAR_ZERO + 8'(w_sec_unit[3:0]);
            end
            sfg_pkg::REQ_BLANK: begin
                o_slots = '{default: sfg_pkg::CHAR_SPACE};
            end
            sfg_pkg::REQ_EXERCISE: begin
                for (int i = 0; i < sfg_pkg::NUM_SLOTS; i++) begin
                    if (r_b_mask[i]) begin
                        o_slots[i] = sfg_pkg::CHAR_ZERO + 8'(r_b_val);
                    end
                end
            end
            sfg_pkg::REQ_TEST: begin
                o_slots = '{default: sfg_pkg::CHAR_EIGHT};
            end
            default: begin
                o_slots = '{default: sfg_pkg::CHAR_SPACE};
            end
        endcase
    end

    assign o_slots_valid = r_b_valid;

endmodule
`default_nettype wire

// ----- src/sfg_queue.sv -----
// short queue of classified frames between the front and back ends
`default_nettype none
module sfg_queue #(
    parameter int DEPTH = sfg_pkg::QUEUE_DEPTH
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push_valid,
    output logic                   o_push_ready,
    input  wire sfg_pkg::t_slots   i_push_data,
    output logic                   o_pop_valid,
    input  wire logic              i_pop_ready,
    output sfg_pkg::t_slots        o_pop_data
);

    // depth must be a power of two, at least two; the block itself does not enforce it
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    sfg_pkg::t_slots    r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               w_push;
    logic               w_pop;

    assign o_push_ready = (r_count != CNT_W'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = i_pop_ready && o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (!w_push && w_pop) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule
`default_nettype wire

// ----- src/sfg_back.sv -----
// back end: walks one frame byte by byte into the output register
`default_nettype none
module sfg_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_slots_valid,
    output logic                   o_slots_ready,
    input  wire sfg_pkg::t_slots   i_slots,
    output logic                   o_res_valid,
    input  wire logic              i_res_ready,
    output sfg_pkg::t_res          o_res
);

    localparam int PW = sfg_pkg::POS_W;

    logic               r_busy;
    logic [PW-1:0]      r_pos;
    sfg_pkg::t_slots    r_slots;
    logic               r_out_valid;
    sfg_pkg::t_res      r_out;
    logic               w_adv;
    logic               w_at_end;
    logic               w_load;

    assign w_adv    = !r_out_valid || i_res_ready;
    assign w_at_end = (r_pos == sfg_pkg::POS_END);
    // next frame follows the carriage return with no gap
    assign w_load   = i_slots_valid && (!r_busy || (w_adv && w_at_end));

    assign o_slots_ready = w_load;
    assign o_res_valid   = r_out_valid;
    assign o_res         = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_pos       <= '0;
        end else begin
            if (w_adv) begin
                r_out_valid <= r_busy;
            end
            if (w_load) begin
                r_busy <= 1'b1;
                r_pos  <= '0;
            end else if (w_adv && r_busy) begin
                if (w_at_end) begin
                    r_busy <= 1'b0;
                end else begin
                    r_pos <= r_pos + PW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_busy) begin
            r_out.frame_byte <= sfg_pkg::frame_char(r_pos, r_slots);
            r_out.last_byte  <= w_at_end;
        end
        if (w_load) begin
            r_slots <= i_slots;
        end
    end

endmodule
`default_nettype wire

// ----- src/scoreboard_frame_generator_top.sv -----
// scoreboard frame generator: request in, seventeen ascii frame bytes out
// a request passes front stages a and b and the queue before the back end sends it
// one byte per cycle from the back end byte counter while the receiver is ready
// front stages and a two-entry queue take further requests while a frame is sent
// reset: synchronous active low, empties the pipeline and queue, output not valid
`default_nettype none
module scoreboard_frame_generator_top #(
    parameter int QUEUE_DEPTH = sfg_pkg::QUEUE_DEPTH
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_req_valid,
    output logic                 o_req_ready,
    input  wire sfg_pkg::t_req   i_req,
    output logic                 o_res_valid,
    input  wire logic            i_res_ready,
    output sfg_pkg::t_res        o_res
);

    logic               w_f_valid;
    logic               w_f_ready;
    sfg_pkg::t_slots    w_f_slots;
    logic               w_q_valid;
    logic               w_q_ready;
    sfg_pkg::t_slots    w_q_slots;

    sfg_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (i_req_valid),
        .o_req_ready   (o_req_ready),
        .i_req         (i_req),
        .o_slots_valid (w_f_valid),
        .i_slots_ready (w_f_ready),
        .o_slots       (w_f_slots)
    );

    sfg_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_f_valid),
        .o_push_ready (w_f_ready),
        .i_push_data  (w_f_slots),
        .o_pop_valid  (w_q_valid),
        .i_pop_ready  (w_q_ready),
        .o_pop_data   (w_q_slots)
    );

    sfg_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_slots_valid (w_q_valid),
        .o_slots_ready (w_q_ready),
        .i_slots       (w_q_slots),
        .o_res_valid   (o_res_valid),
        .i_res_ready   (i_res_ready),
        .o_res         (o_res)
    );

endmodule
`default_nettype wire

// ----- src/sfg_checker.sv -----
// port-level checker for the frame generator output stream, bound to the top level
`default_nettype none
module sfg_checker (
    input wire logic            i_clk,
    input wire logic            i_rst_n,
    input wire logic            o_res_valid,
    input wire logic            i_res_ready,
    input wire sfg_pkg::t_res   o_res
);

    localparam int PW = sfg_pkg::POS_W;

    // position of the byte now on the output within its frame
    logic [PW-1:0] r_cnt;
    logic          w_fixed_space;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (o_res_valid && i_res_ready) begin
            r_cnt <= (r_cnt == sfg_pkg::POS_END) ? '0 : r_cnt + PW'(1);
        end
    end

    assign w_fixed_space = (r_cnt == PW'(3)) || (r_cnt == PW'(5)) || (r_cnt == PW'(7))
                        || (r_cnt == PW'(8)) || (r_cnt == PW'(9)) || (r_cnt == PW'(10))
                        || (r_cnt == PW'(13));

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !i_res_ready |=> o_res_valid && $stable(o_res))
        else $error("output changed while stalled");

    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (o_res.last_byte == (r_cnt == sfg_pkg::POS_END)))
        else $error("last byte flag out of place");

    a_frame_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && ((r_cnt < PW'(3)) || (r_cnt == sfg_pkg::POS_END)) |->
        (o_res.frame_byte == ((r_cnt == sfg_pkg::POS_END) ? sfg_pkg::CHAR_CR
                                                          : sfg_pkg::CHAR_ZERO)))
        else $error("frame header or terminator wrong");

    a_spaces: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && w_fixed_space |-> (o_res.frame_byte == sfg_pkg::CHAR_SPACE))
        else $error("fixed space position not a space");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res_valid)
        else $error("output valid straight after reset");

endmodule

bind scoreboard_frame_generator_top sfg_checker u_sfg_checker (.*);
`default_nettype wire

// ----- verif/tb_scoreboard_frame_generator_top.sv -----
// testbench for the scoreboard frame generator: directed and random requests, byte-wise frame check
module tb_scoreboard_frame_generator_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_PER_PHASE = 147;
    localparam int DRAIN_CYCLES     = 40;

    logic          i_clk       = 1'b0;
    logic          i_rst_n     = 1'b0;
    logic          i_req_valid = 1'b0;
    logic          i_res_ready = 1'b0;
    sfg_pkg::t_req i_req       = '0;
    logic          o_req_ready;
    logic          o_res_valid;
    sfg_pkg::t_res o_res;

    int            req_idle_pct = 31;
    int            res_idle_pct = 53;
    int            mismatch_count = 0;
    sfg_pkg::t_res pending_frame_bytes[$];

    scoreboard_frame_generator_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_res_valid (o_res_valid),
        .i_res_ready (i_res_ready),
        .o_res       (o_res)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // receiver back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_res_ready <= 1'b0;
        end else begin
            i_res_ready <= ($urandom_range(99) >= res_idle_pct);
        end
    end

    function automatic logic [7:0] ascii_digit(input int unsigned v);
        return sfg_pkg::CHAR_ZERO + 8'(v % 10);
    endfunction

    // works out the seventeen bytes a request must produce and queues them
    function automatic void predict_frame_bytes(input sfg_pkg::t_req r);
        logic [7:0]    frame [sfg_pkg::BYTES_PER_FRAME];
        int unsigned   slot_pos [sfg_pkg::NUM_SLOTS];
        int unsigned   clock_secs;
        int unsigned   mins;
        int unsigned   secs;
        sfg_pkg::t_res b;
        slot_pos = '{int'(sfg_pkg::POS_HOME), int'(sfg_pkg::POS_AWAY),
                     int'(sfg_pkg::POS_MIN_TENS), int'(sfg_pkg::POS_MIN_UNIT),
                     int'(sfg_pkg::POS_SEC_TENS), int'(sfg_pkg::POS_SEC_UNIT)};
        for (int i = 0; i < sfg_pkg::BYTES_PER_FRAME; i++) frame[i] = sfg_pkg::CHAR_SPACE;
        frame[0] = sfg_pkg::CHAR_ZERO;
        frame[1] = sfg_pkg::CHAR_ZERO;
        frame[2] = sfg_pkg::CHAR_ZERO;
        frame[sfg_pkg::LAST_POS] = sfg_pkg::CHAR_CR;
        case (r.req_type)
            sfg_pkg::REQ_MATCH: begin
                clock_secs = r.game_secs;
                if (clock_secs > sfg_pkg::CLOCK_LIMIT) clock_secs = sfg_pkg::CLOCK_LIMIT;
                mins = (clock_secs / sfg_pkg::SECS_PER_MIN) % 100;
                secs = clock_secs % sfg_pkg::SECS_PER_MIN;
                frame[slot_pos[0]] = ascii_digit(r.home_score);
                frame[slot_pos[1]] = ascii_digit(r.away_score);
                frame[slot_pos[2]] = ascii_digit(mins / 10);
                frame[slot_pos[3]] = ascii_digit(mins);
                frame[slot_pos[4]] = ascii_digit(secs / 10);
                frame[slot_pos[5]] = ascii_digit(secs);
            end
            sfg_pkg::REQ_EXERCISE: begin
                for (int i = 0; i < sfg_pkg::NUM_SLOTS; i++)
                    if (r.digit_mask[i]) frame[slot_pos[i]] = ascii_digit(r.exercise_value);
            end
            sfg_pkg::REQ_TEST: begin
                for (int i = 0; i < sfg_pkg::NUM_SLOTS; i++)
                    frame[slot_pos[i]] = sfg_pkg::CHAR_EIGHT;
            end
            default: ;
        endcase
        for (int i = 0; i < sfg_pkg::BYTES_PER_FRAME; i++) begin
            b.frame_byte = frame[i];
            b.last_byte  = (i == sfg_pkg::LAST_POS);
            pending_frame_bytes.push_back(b);
        end
    endfunction

    task automatic send_request(input sfg_pkg::t_req r);
        int gap;
        gap = 0;
        while ($urandom_range(99) < req_idle_pct) gap++;
        if (gap > 0) begin
            i_req_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_req_valid <= 1'b1;
        i_req       <= r;
        do @(posedge i_clk); while (!o_req_ready);
        predict_frame_bytes(r);
    endtask

    function automatic sfg_pkg::t_req make_request(input logic [1:0] kind, input int home,
                                                   input int away, input int secs,
                                                   input int mask, input int val);
        sfg_pkg::t_req r;
        r.req_type       = kind;
        r.home_score     = 8'(home);
        r.away_score     = 8'(away);
        r.game_secs      = 16'(secs);
        r.digit_mask     = 6'(mask);
        r.exercise_value = 8'(val);
        return r;
    endfunction

    function automatic sfg_pkg::t_req random_request();
        sfg_pkg::t_req r;
        r.req_type       = 2'($urandom_range(3));
        r.home_score     = 8'($urandom);
        r.away_score     = 8'($urandom);
        r.digit_mask     = 6'($urandom);
        r.exercise_value = 8'($urandom);
        // keep most clock values below the clamp, with some around it and some anywhere
        case ($urandom_range(9))
            0, 1:    r.game_secs = 16'($urandom);
            2:       r.game_secs = 16'($urandom_range(5990, 6010));
            default: r.game_secs = 16'($urandom_range(0, sfg_pkg::CLOCK_LIMIT));
        endcase
        return r;
    endfunction

    task automatic test_match_requests();
        send_request(make_request(sfg_pkg::REQ_MATCH, 0, 0, 0, 0, 0));
        send_request(make_request(sfg_pkg::REQ_MATCH, 255, 255, 65535, 63, 255));
        send_request(make_request(sfg_pkg::REQ_MATCH, 9, 10, sfg_pkg::CLOCK_LIMIT, 0, 0));
        send_request(make_request(sfg_pkg::REQ_MATCH, 19, 99, sfg_pkg::CLOCK_LIMIT + 1, 21, 7));
        send_request(make_request(sfg_pkg::REQ_MATCH, 100, 1, 59, 42, 3));
        send_request(make_request(sfg_pkg::REQ_MATCH, 3, 250, 60, 0, 128));
        send_request(make_request(sfg_pkg::REQ_MATCH, 128, 127, 3599, 63, 0));
    endtask

    task automatic test_blank_requests();
        send_request(make_request(sfg_pkg::REQ_BLANK, 0, 0, 0, 0, 0));
        send_request(make_request(sfg_pkg::REQ_BLANK, 255, 255, 65535, 63, 255));
    endtask

    task automatic test_exercise_requests();
        // mask of zero must give the blank frame
        send_request(make_request(sfg_pkg::REQ_EXERCISE, 0, 0, 0, 0, 5));
        send_request(make_request(sfg_pkg::REQ_EXERCISE, 0, 0, 0, 63, 255));
        for (int i = 0; i < sfg_pkg::NUM_SLOTS; i++)
            send_request(make_request(sfg_pkg::REQ_EXERCISE, 77, 33, 1234, 1 << i, 9 + i));
    endtask

    task automatic test_pattern_requests();
        send_request(make_request(sfg_pkg::REQ_TEST, 0, 0, 0, 0, 0));
        send_request(make_request(sfg_pkg::REQ_TEST, 255, 255, 65535, 63, 255));
    endtask

    task automatic test_random_requests(input int count);
        repeat (count) send_request(random_request());
    endtask

    // compares each accepted byte with the oldest predicted one
    always @(posedge i_clk) begin
        sfg_pkg::t_res want;
        if (i_rst_n && o_res_valid && i_res_ready) begin
            if (pending_frame_bytes.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected frame byte: expected none, actual %h last %b",
                         $time, o_res.frame_byte, o_res.last_byte);
            end else begin
                want = pending_frame_bytes.pop_front();
                if (o_res.frame_byte !== want.frame_byte) begin
                    mismatch_count++;
                    $display("%0t: frame_byte mismatch: expected %h, actual %h",
                             $time, want.frame_byte, o_res.frame_byte);
                end
                if (o_res.last_byte !== want.last_byte) begin
                    mismatch_count++;
                    $display("%0t: last_byte mismatch: expected %b, actual %b",
                             $time, want.last_byte, o_res.last_byte);
                end
            end
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_match_requests();
        test_blank_requests();
        test_exercise_requests();
        test_pattern_requests();
        test_random_requests(RANDOM_PER_PHASE);

        req_idle_pct = 53;
        res_idle_pct = 31;
        test_random_requests(RANDOM_PER_PHASE);

        req_idle_pct = 0;
        res_idle_pct = 0;
        test_random_requests(RANDOM_PER_PHASE);

        i_req_valid <= 1'b0;
        while (pending_frame_bytes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && pending_frame_bytes.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- scoreboard_frame_generator_top.f -----
src/sfg_pkg.sv
src/sfg_front.sv
src/sfg_queue.sv
src/sfg_back.sv
src/scoreboard_frame_generator_top.sv
src/sfg_checker.sv
verif/tb_scoreboard_frame_generator_top.sv
